[rtl/core/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Command codes, field widths and the reset value of the half-period setting.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    // Command codes as carried in the input func field
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    // Sequence step within one command (0 to 5)
    typedef logic [2:0] step_t;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned FUNC_W = 3;

    localparam logic [BYTE_W-1:0] HALF_PERIOD_RESET = 8'd10;

    // Last step of a byte transfer, reached once eight bits have moved
    localparam step_t STEP_LAST = 3'd5;

    // Packed channel widths
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 4;
    localparam int unsigned M_TDATA_W = 16;

endpackage

`default_nettype wire

[rtl/core/i2c_master_byte_engine.sv]
// ----------------------------------------------------------------------------
// I2C master byte engine
// Open-drain I2C bus master without clock stretching, one item per bus tick.
// ----------------------------------------------------------------------------
//
// Usage:
//   Each item on the slave channel is one bus tick: the sampled SDA level and
//   an optional command (idle, start, stop, write byte, read byte). Every
//   accepted item yields exactly one result item on the master channel with
//   the SCL/SDA pull-low levels, busy, a one-item done pulse, the last read
//   byte and the last write's ACK flag.
//   The result is registered, in the cycle after acceptance; throughput is
//   one item per cycle while m_tready is high (single state register stage).
//   A command is taken only while the engine is not busy; commands offered
//   while busy, or with an unknown code, are dropped.
//   half_period_ticks sets the ticks per half-period wait (zero acts as one);
//   write it only while the engine is idle.
//   Reset (aresetn low, synchronous) releases both lines, clears the sequencer,
//   the received byte and the ACK flag, empties the result register and loads
//   the half-period setting with ten.
//   When the receiver stalls, the result item holds and s_tready drops until
//   it is taken; an item is accepted in the same cycle the result leaves.
//
`default_nettype none

module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration: half_period_ticks
    input  wire logic                  cfg_wr_en,
    input  wire logic [BYTE_W-1:0]     cfg_wr_data,

    // Input items
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [0] cmd_valid, [3:1] func
    input  wire logic [S_TUSER_W-1:0]  s_tuser,

    // Result items
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // [0] scl_drive_low, [1] sda_drive_low, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] acked, [15:13] zero
    output      logic [M_TDATA_W-1:0]  m_tdata
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] half_period_reg;
    step_t             step_reg,       step_next;
    logic [BYTE_W-1:0] wait_count_reg, wait_count_next;
    logic [2:0]        bit_count_reg,  bit_count_next;
    logic [BYTE_W-1:0] shift_reg,      shift_next;
    cmd_t              active_cmd_reg, active_cmd_next;
    logic              scl_low_reg,    scl_low_next;
    logic              sda_low_reg,    sda_low_next;
    logic              ack_choice_reg, ack_choice_next;
    logic              ack_seen_reg,   ack_seen_next;
    logic              busy_reg,       busy_next;
    logic [BYTE_W-1:0] rx_hold_reg,    rx_hold_next;
    logic              done_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    logic              in_cmd_valid;
    logic [FUNC_W-1:0] in_func;
    logic [BYTE_W-1:0] in_tx_byte;
    logic              in_send_ack;
    logic              in_sda;
    logic              accept;

    assign in_cmd_valid = s_tuser[0];
    assign in_func      = s_tuser[3:1];
    assign in_tx_byte   = s_tdata[7:0];
    assign in_send_ack  = s_tdata[8];
    assign in_sda       = s_tdata[9];

    // Take a new item whenever the result register is empty or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Sequencer: one tick of work per accepted item
    // ------------------------------------------------------------------
    logic              seg_go;
    cmd_t              seg_cmd;
    step_t             seg_step;
    logic [BYTE_W-1:0] seg_shift;
    logic [2:0]        seg_bits;
    logic              seg_end;
    logic [BYTE_W-1:0] wait_load;

    // A half-period of zero counts as one tick
    assign wait_load = (half_period_reg == '0) ? '0 : half_period_reg - 1'b1;

    always_comb begin
        step_next       = step_reg;
        wait_count_next = wait_count_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        active_cmd_next = active_cmd_reg;
        scl_low_next    = scl_low_reg;
        sda_low_next    = sda_low_reg;
        ack_choice_next = ack_choice_reg;
        ack_seen_next   = ack_seen_reg;
        busy_next       = busy_reg;
        rx_hold_next    = rx_hold_reg;
        done_next       = 1'b0;

        seg_go    = 1'b0;
        seg_cmd   = active_cmd_reg;
        seg_step  = step_reg;
        seg_shift = shift_reg;
        seg_bits  = bit_count_reg;
        seg_end   = 1'b0;

        if (busy_reg) begin
            if (wait_count_reg != '0) begin
                wait_count_next = wait_count_reg - 1'b1;
            end else begin
                seg_go = 1'b1;
            end
        end else if (in_cmd_valid && (in_func <= FUNC_W'(CMD_READ))) begin
            // Launch a new command at its first step
            seg_go          = 1'b1;
            seg_cmd         = cmd_t'(in_func);
            seg_step        = '0;
            seg_bits        = '0;
            active_cmd_next = cmd_t'(in_func);
            bit_count_next  = '0;
            busy_next       = 1'b1;
            if (cmd_t'(in_func) == CMD_WRITE) begin
                seg_shift  = in_tx_byte;
                shift_next = in_tx_byte;
            end
            if (cmd_t'(in_func) == CMD_READ) begin
                ack_choice_next = in_send_ack;
            end
        end

        if (seg_go) begin
            case (seg_cmd)
                CMD_IDLE: begin
                    if (seg_step == 3'd0) begin
                        sda_low_next = 1'b0;
                        scl_low_next = 1'b0;
                        step_next    = 3'd1;
                    end else begin
                        seg_end = 1'b1;
                    end
                end
                CMD_START: begin
                    case (seg_step)
                        3'd0: begin
                            sda_low_next = 1'b0;
                            scl_low_next = 1'b0;
                            step_next    = 3'd1;
                        end
                        3'd1: begin
                            sda_low_next = 1'b1;
                            step_next    = 3'd2;
                        end
                        3'd2: begin
                            scl_low_next = 1'b1;
                            step_next    = 3'd3;
                        end
                        default: seg_end = 1'b1;
                    endcase
                end
                CMD_STOP: begin
                    case (seg_step)
                        3'd0: begin
                            sda_low_next = 1'b1;
                            step_next    = 3'd1;
                        end
                        3'd1: begin
                            scl_low_next = 1'b0;
                            step_next    = 3'd2;
                        end
                        3'd2: begin
                            sda_low_next = 1'b0;
                            step_next    = 3'd3;
                        end
                        default: seg_end = 1'b1;
                    endcase
                end
                CMD_WRITE: begin
                    case (seg_step)
                        3'd0: begin
                            bit_count_next = '0;
                            sda_low_next   = !seg_shift[BYTE_W-1];
                            shift_next     = {seg_shift[BYTE_W-2:0], 1'b0};
                            step_next      = 3'd1;
                        end
                        3'd1: begin
                            scl_low_next = 1'b0;
                            step_next    = 3'd2;
                        end
                        3'd2: begin
                            scl_low_next = 1'b1;
                            if (seg_bits != 3'd7) begin
                                bit_count_next = seg_bits + 1'b1;
                                sda_low_next   = !seg_shift[BYTE_W-1];
                                shift_next     = {seg_shift[BYTE_W-2:0], 1'b0};
                                step_next      = 3'd1;
                            end else begin
                                // Release SDA for the slave's ACK
                                sda_low_next = 1'b0;
                                step_next    = 3'd3;
                            end
                        end
                        3'd3: begin
                            scl_low_next = 1'b0;
                            step_next    = 3'd4;
                        end
                        3'd4: begin
                            ack_seen_next = !in_sda;
                            scl_low_next  = 1'b1;
                            step_next     = STEP_LAST;
                        end
                        default: seg_end = 1'b1;
                    endcase
                end
                CMD_READ: begin
                    case (seg_step)
                        3'd0: begin
                            bit_count_next = '0;
                            shift_next     = '0;
                            sda_low_next   = 1'b0;
                            step_next      = 3'd1;
                        end
                        3'd1: begin
                            scl_low_next = 1'b0;
                            step_next    = 3'd2;
                        end
                        3'd2: begin
                            // Sample after SCL has been high a full half-period
                            shift_next   = {seg_shift[BYTE_W-2:0], in_sda};
                            scl_low_next = 1'b1;
                            if (seg_bits != 3'd7) begin
                                bit_count_next = seg_bits + 1'b1;
                                step_next      = 3'd1;
                            end else begin
                                sda_low_next = ack_choice_reg;
                                step_next    = 3'd3;
                            end
                        end
                        3'd3: begin
                            scl_low_next = 1'b0;
                            step_next    = 3'd4;
                        end
                        3'd4: begin
                            scl_low_next = 1'b1;
                            sda_low_next = 1'b0;
                            step_next    = STEP_LAST;
                        end
                        default: begin
                            rx_hold_next = seg_shift;
                            seg_end      = 1'b1;
                        end
                    endcase
                end
                default: seg_end = 1'b1;
            endcase

            // Every step that does not end the command opens a wait
            if (!seg_end) begin
                wait_count_next = wait_load;
            end else if (busy_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
            step_reg        <= '0;
            wait_count_reg  <= '0;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            active_cmd_reg  <= CMD_IDLE;
            scl_low_reg     <= 1'b0;
            sda_low_reg     <= 1'b0;
            ack_choice_reg  <= 1'b0;
            ack_seen_reg    <= 1'b0;
            busy_reg        <= 1'b0;
            rx_hold_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                half_period_reg <= cfg_wr_data;
            end
            if (accept) begin
                step_reg       <= step_next;
                wait_count_reg <= wait_count_next;
                bit_count_reg  <= bit_count_next;
                shift_reg      <= shift_next;
                active_cmd_reg <= active_cmd_next;
                scl_low_reg    <= scl_low_next;
                sda_low_reg    <= sda_low_next;
                ack_choice_reg <= ack_choice_next;
                ack_seen_reg   <= ack_seen_next;
                busy_reg       <= busy_next;
                rx_hold_reg    <= rx_hold_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg   <= 1'b0;
            end
        end
    end

    // Result payload: no reset needed, qualified by m_tvalid
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {3'b000, ack_seen_next, rx_hold_next, done_next, busy_next,
                            sda_low_next, scl_low_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // A done pulse always comes with busy dropped in the same item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
        else $error("done raised while busy still set");

    // A running wait never ends a command
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && busy_reg && (wait_count_reg != '0)) |=> busy_reg)
        else $error("command ended during a half-period wait");

    // The sequencer never runs past the final step
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (step_reg <= STEP_LAST))
        else $error("sequencer step out of range");

    // State moves only with an accepted item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!accept && $past(aresetn)) |=> ($stable(busy_reg) && $stable(step_reg)))
        else $error("sequencer moved without an accepted item");
`endif

endmodule

`default_nettype wire
